@@ src/button_long_press_led_controller_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the button LED controller checks.
// ----------------------------------------------------------------------------
`ifndef BUTTON_LONG_PRESS_LED_CONTROLLER_CORE_ASSERT_SVH
`define BUTTON_LONG_PRESS_LED_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define BLPL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define BLPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/blpl_pkg.sv @@
// ----------------------------------------------------------------------------
// blpl_pkg
// Types, register indexes, reset values and event codes of the button LED
// controller.
// ----------------------------------------------------------------------------
package blpl_pkg;

  localparam int unsigned RegWidth      = 16;
  localparam int unsigned RegIndexWidth = 3;
  localparam int unsigned EventWidth    = 3;
  localparam int unsigned CountWidthDef = 16;

  localparam logic [RegIndexWidth-1:0] RegDebounce    = 3'd0;
  localparam logic [RegIndexWidth-1:0] RegHoldStep    = 3'd1;
  localparam logic [RegIndexWidth-1:0] RegHoldLimit   = 3'd2;
  localparam logic [RegIndexWidth-1:0] RegReleasePoll = 3'd3;
  localparam logic [RegIndexWidth-1:0] RegAutoOff     = 3'd4;

  localparam logic [RegWidth-1:0] DebounceReset    = 16'd50;
  localparam logic [RegWidth-1:0] HoldStepReset    = 16'd10;
  localparam logic [RegWidth-1:0] HoldLimitReset   = 16'd2000;
  localparam logic [RegWidth-1:0] ReleasePollReset = 16'd50;
  localparam logic [RegWidth-1:0] AutoOffReset     = 16'd10000;

  typedef enum logic [EventWidth-1:0] {
    EV_NONE      = 3'd0,
    EV_PRESS     = 3'd1,
    EV_CLICK     = 3'd2,
    EV_FORCE_OFF = 3'd3,
    EV_AUTO_OFF  = 3'd4
  } event_e;

  typedef struct packed {
    logic [RegWidth-1:0] debounce_ticks;
    logic [RegWidth-1:0] hold_step_ticks;
    logic [RegWidth-1:0] hold_limit_ticks;
    logic [RegWidth-1:0] release_poll_ticks;
    logic [RegWidth-1:0] auto_off_ticks;
  } cfg_t;

  typedef struct packed {
    logic   led_on;
    event_e event_code;
  } result_t;

  typedef struct packed {
    logic step;
    logic level;
  } tick_t;

endpackage

@@ src/blpl_in_stage.sv @@
// ----------------------------------------------------------------------------
// blpl_in_stage
// Input register: holds one button sample until the result stage takes it.
// ----------------------------------------------------------------------------
module blpl_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 button_level_i,
  input  logic                 out_ready_i,
  output blpl_pkg::tick_t      tick_o
);

  logic valid_q, valid_d;
  logic level_q;
  logic accept;
  logic advance;

  assign advance    = valid_q && out_ready_i;
  assign in_stall_o = valid_q && !out_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      level_q <= button_level_i;
    end
  end

  assign tick_o.step  = advance;
  assign tick_o.level = level_q;

endmodule

@@ src/blpl_core.sv @@
// ----------------------------------------------------------------------------
// blpl_core
// Button state machine, hold accumulator and auto-off countdown; advances one
// tick per transaction and presents the result of that tick.
// ----------------------------------------------------------------------------
module blpl_core #(
  parameter int unsigned COUNT_WIDTH = blpl_pkg::CountWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  blpl_pkg::tick_t   tick_i,
  input  blpl_pkg::cfg_t    cfg_i,
  output blpl_pkg::result_t result_o
);

  localparam int unsigned ExtWidth =
    (COUNT_WIDTH > blpl_pkg::RegWidth) ? COUNT_WIDTH : blpl_pkg::RegWidth;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [blpl_pkg::RegWidth-1:0] reg_t;

  localparam cnt_t CntMax = '1;
  localparam cnt_t CntOne = cnt_t'(1);

  typedef enum logic [1:0] {
    PhIdle,
    PhDebounce,
    PhHold,
    PhLockout
  } phase_e;

  function automatic cnt_t clampc(reg_t v);
    logic [ExtWidth-1:0] ve;
    logic [ExtWidth-1:0] me;
    ve = ExtWidth'(v);
    me = ExtWidth'(CntMax);
    clampc = (ve > me) ? CntMax : ve[COUNT_WIDTH-1:0];
  endfunction

  function automatic cnt_t sat_add(cnt_t a, cnt_t b);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[COUNT_WIDTH] ? CntMax : s[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic reached(cnt_t v, reg_t lim);
    reached = (v >= clampc(lim)) || (v == CntMax);
  endfunction

  phase_e phase_q, phase_d;
  logic   prev_level_q;
  cnt_t   phase_cnt_q, phase_cnt_d;
  cnt_t   hold_acc_q, hold_acc_d;
  cnt_t   remain_q, remain_d;
  logic   running_q, running_d;
  logic   led_q, led_d;
  blpl_pkg::event_e ev;
  cnt_t   cnt_inc;
  cnt_t   hold_next;
  logic   lvl;

  assign lvl       = tick_i.level;
  assign cnt_inc   = sat_add(phase_cnt_q, CntOne);
  assign hold_next = sat_add(hold_acc_q, clampc(cfg_i.hold_step_ticks));

  always_comb begin
    phase_d     = phase_q;
    phase_cnt_d = phase_cnt_q;
    hold_acc_d  = hold_acc_q;
    remain_d    = remain_q;
    running_d   = running_q;
    led_d       = led_q;
    ev          = blpl_pkg::EV_NONE;

    if (running_q) begin
      if (remain_q <= CntOne) begin
        remain_d  = '0;
        running_d = 1'b0;
        led_d     = 1'b0;
        ev        = blpl_pkg::EV_AUTO_OFF;
      end else begin
        remain_d = remain_q - CntOne;
      end
    end

    case (phase_q)
      PhIdle: begin
        if (prev_level_q && !lvl) begin
          phase_d     = PhDebounce;
          phase_cnt_d = '0;
        end
      end
      PhDebounce: begin
        phase_cnt_d = cnt_inc;
        if (reached(cnt_inc, cfg_i.debounce_ticks)) begin
          phase_cnt_d = '0;
          if (!lvl) begin
            led_d      = 1'b1;
            remain_d   = clampc(cfg_i.auto_off_ticks);
            running_d  = 1'b1;
            hold_acc_d = clampc(cfg_i.debounce_ticks);
            phase_d    = PhHold;
            ev         = blpl_pkg::EV_PRESS;
          end else begin
            phase_d = PhIdle;
          end
        end
      end
      PhHold: begin
        phase_cnt_d = cnt_inc;
        if (reached(cnt_inc, cfg_i.hold_step_ticks)) begin
          phase_cnt_d = '0;
          hold_acc_d  = hold_next;
          if (reached(hold_next, cfg_i.hold_limit_ticks)) begin
            led_d     = 1'b0;
            running_d = 1'b0;
            remain_d  = '0;
            phase_d   = lvl ? PhIdle : PhLockout;
            ev        = blpl_pkg::EV_FORCE_OFF;
          end else if (lvl) begin
            phase_d = PhIdle;
            ev      = blpl_pkg::EV_CLICK;
          end
        end
      end
      default: begin
        phase_cnt_d = cnt_inc;
        if (reached(cnt_inc, cfg_i.release_poll_ticks)) begin
          phase_cnt_d = '0;
          if (lvl) begin
            phase_d = PhIdle;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      prev_level_q <= 1'b1;
      phase_cnt_q  <= '0;
      hold_acc_q   <= '0;
      remain_q     <= '0;
      running_q    <= 1'b0;
      led_q        <= 1'b0;
    end else if (tick_i.step) begin
      phase_q      <= phase_d;
      prev_level_q <= lvl;
      phase_cnt_q  <= phase_cnt_d;
      hold_acc_q   <= hold_acc_d;
      remain_q     <= remain_d;
      running_q    <= running_d;
      led_q        <= led_d;
    end
  end

  assign result_o.led_on     = led_d;
  assign result_o.event_code = ev;

endmodule

@@ src/blpl_out_stage.sv @@
// ----------------------------------------------------------------------------
// blpl_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module blpl_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  blpl_pkg::result_t result_i,
  output logic              out_ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              led_on_o,
  output logic [blpl_pkg::EventWidth-1:0] event_code_o
);

  logic              valid_q, valid_d;
  blpl_pkg::result_t result_q;

  assign out_ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q && out_stall_i;
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign led_on_o     = result_q.led_on;
  assign event_code_o = result_q.event_code;

endmodule

@@ src/button_long_press_led_controller_core.sv @@
// ----------------------------------------------------------------------------
// button_long_press_led_controller_core
// Debounced push button with long-press lockout and auto-off timer for an LED.
// ----------------------------------------------------------------------------
// Each transaction carries one tick's button sample and yields exactly one
// result: the LED level after the tick and an event code. The block takes a
// transaction every clock cycle while the input does not stall. An accepted
// sample waits in the input register and feeds the combinational state
// update, whose result is loaded into the result register. A stalled result
// holds the input register, and the input stalls once that register is also
// full. Configuration registers are to be written through the plain write
// port only while no transaction is in flight; the block does not enforce it.
module button_long_press_led_controller_core #(
  parameter int unsigned COUNT_WIDTH = blpl_pkg::CountWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [blpl_pkg::RegIndexWidth-1:0]  cfg_index_i,
  input  logic [blpl_pkg::RegWidth-1:0]       cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                button_level_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                led_on_o,
  output logic [blpl_pkg::EventWidth-1:0]     event_code_o
);

  blpl_pkg::cfg_t    cfg_q;
  blpl_pkg::tick_t   tick;
  blpl_pkg::result_t result;
  logic              out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks     <= blpl_pkg::DebounceReset;
      cfg_q.hold_step_ticks    <= blpl_pkg::HoldStepReset;
      cfg_q.hold_limit_ticks   <= blpl_pkg::HoldLimitReset;
      cfg_q.release_poll_ticks <= blpl_pkg::ReleasePollReset;
      cfg_q.auto_off_ticks     <= blpl_pkg::AutoOffReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        blpl_pkg::RegDebounce:    cfg_q.debounce_ticks     <= cfg_wdata_i;
        blpl_pkg::RegHoldStep:    cfg_q.hold_step_ticks    <= cfg_wdata_i;
        blpl_pkg::RegHoldLimit:   cfg_q.hold_limit_ticks   <= cfg_wdata_i;
        blpl_pkg::RegReleasePoll: cfg_q.release_poll_ticks <= cfg_wdata_i;
        blpl_pkg::RegAutoOff:     cfg_q.auto_off_ticks     <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  blpl_in_stage u_in_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .button_level_i (button_level_i),
    .out_ready_i    (out_ready),
    .tick_o         (tick)
  );

  blpl_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  blpl_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (tick.step),
    .result_i     (result),
    .out_ready_o  (out_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .led_on_o     (led_on_o),
    .event_code_o (event_code_o)
  );

endmodule

@@ src/blpl_checker.sv @@
// ----------------------------------------------------------------------------
// blpl_checker
// Port-level checks of the button LED controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "button_long_press_led_controller_core_assert.svh"

module blpl_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            led_on_o,
  input logic [blpl_pkg::EventWidth-1:0] event_code_o
);

  `BLPL_ASSERT_NOW(a_press_lights, out_valid_o && (event_code_o == blpl_pkg::EV_PRESS), led_on_o, "press accepted with LED off")
  `BLPL_ASSERT_NOW(a_off_darkens, out_valid_o && ((event_code_o == blpl_pkg::EV_FORCE_OFF) || (event_code_o == blpl_pkg::EV_AUTO_OFF)), !led_on_o, "off event with LED lit")
  `BLPL_ASSERT_NOW(a_empty_no_stall, !out_valid_o, !in_stall_o, "input stalled while result register empty")
  `BLPL_ASSERT_NEXT(a_result_holds, out_valid_o && out_stall_i, out_valid_o && $stable(led_on_o) && $stable(event_code_o), "stalled result changed")

endmodule

bind button_long_press_led_controller_core blpl_checker u_blpl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .led_on_o     (led_on_o),
  .event_code_o (event_code_o)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the button LED controller core one tick at a time. A behavioral copy
// of the debounce, hold, lockout and auto-off logic predicts led_on and
// event_code for every accepted transaction. A short table of ticks covers
// press, click, forced off, auto off, zero intervals and events that fall on
// the same tick. Random press gestures under changing register settings
// follow. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import blpl_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DEBOUNCE,
    PH_HOLD,
    PH_LOCKOUT
  } btn_phase_e;

  typedef enum int unsigned {
    CFG_SMALL,
    CFG_ZEROS,
    CFG_RESET,
    CFG_WIDE
  } cfg_mode_e;

  localparam int unsigned CountWidth = CountWidthDef;
  localparam logic [CountWidth-1:0] CountMax = '1;
  localparam int unsigned IdleLimit = 1000;
  localparam int unsigned RandomTicks = 1350;

  typedef struct {
    logic                  level_q;
    btn_phase_e            phase;
    logic [CountWidth-1:0] phase_cnt;
    logic [CountWidth-1:0] hold_acc;
    logic [CountWidth-1:0] countdown;
    logic                  countdown_on;
    logic                  led;
  } btn_state_t;

  typedef struct {
    int     cfg_sel;
    logic   level;
    logic   typed;
    logic   led;
    event_e ev;
  } tick_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [RegIndexWidth-1:0] cfg_index_i = RegDebounce;
  logic [RegWidth-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic button_level_i = 1'b1;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic led_on_o;
  logic [EventWidth-1:0] event_code_o;

  btn_state_t btn = '{1'b1, PH_IDLE, '0, '0, '0, 1'b0, 1'b0};
  cfg_t cfg = '{DebounceReset, HoldStepReset, HoldLimitReset, ReleasePollReset,
                AutoOffReset};
  result_t led_events_due[$];
  result_t head_due;
  int unsigned errors = 0;
  int unsigned ticks_sent = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  logic quiet = 1'b0;

  cfg_t cfg_sets [3] = '{
    '{16'd2, 16'd1, 16'd4, 16'd2, 16'd6},
    '{default: '0},
    '{16'd1, 16'd3, 16'd100, 16'd1, 16'd2}
  };

  tick_row_t directed [28] = '{
    '{-1, 1'b1, 1'b1, 1'b0, EV_NONE},
    '{-1, 1'b0, 1'b1, 1'b0, EV_NONE},
    '{-1, 1'b1, 1'b1, 1'b0, EV_NONE},
    // press, forced off on a released tick, bounce rejected, click
    '{0, 1'b1, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b1, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b1, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b1, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b1, 1'b0, 1'b0, EV_NONE},
    // zero intervals: auto off and forced off on one tick, then lockout
    '{1, 1'b1, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b1, 1'b0, 1'b0, EV_NONE},
    // auto off while held, then click with the LED already off
    '{2, 1'b1, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b0, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b1, 1'b0, 1'b0, EV_NONE},
    '{-1, 1'b1, 1'b0, 1'b0, EV_NONE}
  };

  button_long_press_led_controller_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .button_level_i (button_level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .led_on_o       (led_on_o),
    .event_code_o   (event_code_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [CountWidth-1:0] to_count(input logic [RegWidth-1:0] v);
    return (v > CountMax) ? CountMax : v[CountWidth-1:0];
  endfunction

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] a,
                                                    input logic [CountWidth-1:0] b);
    logic [CountWidth:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CountWidth] ? CountMax : s[CountWidth-1:0];
  endfunction

  function automatic logic reached(input logic [CountWidth-1:0] v,
                                   input logic [RegWidth-1:0] lim);
    return (v >= to_count(lim)) || (v == CountMax);
  endfunction

  function automatic result_t advance_tick(input logic lvl);
    result_t r;
    event_e ev;
    ev = EV_NONE;
    if (btn.countdown_on) begin
      if (btn.countdown <= 1) begin
        btn.countdown = '0;
        btn.countdown_on = 1'b0;
        btn.led = 1'b0;
        ev = EV_AUTO_OFF;
      end else begin
        btn.countdown = btn.countdown - 1'b1;
      end
    end
    case (btn.phase)
      PH_IDLE: begin
        if (btn.level_q && !lvl) begin
          btn.phase = PH_DEBOUNCE;
          btn.phase_cnt = '0;
        end
      end
      PH_DEBOUNCE: begin
        btn.phase_cnt = sat_inc(btn.phase_cnt, CountWidth'(1));
        if (reached(btn.phase_cnt, cfg.debounce_ticks)) begin
          btn.phase_cnt = '0;
          if (!lvl) begin
            btn.led = 1'b1;
            btn.countdown = to_count(cfg.auto_off_ticks);
            btn.countdown_on = 1'b1;
            btn.hold_acc = to_count(cfg.debounce_ticks);
            btn.phase = PH_HOLD;
            ev = EV_PRESS;
          end else begin
            btn.phase = PH_IDLE;
          end
        end
      end
      PH_HOLD: begin
        btn.phase_cnt = sat_inc(btn.phase_cnt, CountWidth'(1));
        if (reached(btn.phase_cnt, cfg.hold_step_ticks)) begin
          btn.phase_cnt = '0;
          btn.hold_acc = sat_inc(btn.hold_acc, to_count(cfg.hold_step_ticks));
          if (reached(btn.hold_acc, cfg.hold_limit_ticks)) begin
            btn.led = 1'b0;
            btn.countdown_on = 1'b0;
            btn.countdown = '0;
            btn.phase = lvl ? PH_IDLE : PH_LOCKOUT;
            ev = EV_FORCE_OFF;
          end else if (lvl) begin
            btn.phase = PH_IDLE;
            ev = EV_CLICK;
          end
        end
      end
      default: begin
        btn.phase_cnt = sat_inc(btn.phase_cnt, CountWidth'(1));
        if (reached(btn.phase_cnt, cfg.release_poll_ticks)) begin
          btn.phase_cnt = '0;
          if (lvl) btn.phase = PH_IDLE;
        end
      end
    endcase
    btn.level_q = lvl;
    r.led_on = btn.led;
    r.event_code = ev;
    return r;
  endfunction

  function automatic cfg_t pick_cfg(input cfg_mode_e mode);
    cfg_t c;
    c.debounce_ticks = RegWidth'($urandom_range(1, 6));
    c.hold_step_ticks = RegWidth'($urandom_range(1, 4));
    c.hold_limit_ticks = RegWidth'($urandom_range(1, 24));
    c.release_poll_ticks = RegWidth'($urandom_range(1, 6));
    c.auto_off_ticks = RegWidth'($urandom_range(1, 48));
    case (mode)
      CFG_ZEROS: begin
        if ($urandom_range(0, 2) == 0) c.debounce_ticks = '0;
        if ($urandom_range(0, 2) == 0) c.hold_step_ticks = '0;
        if ($urandom_range(0, 2) == 0) c.hold_limit_ticks = '0;
        if ($urandom_range(0, 2) == 0) c.release_poll_ticks = '0;
        if ($urandom_range(0, 2) == 0) c.auto_off_ticks = '0;
      end
      CFG_RESET: begin
        c = '{DebounceReset, HoldStepReset, HoldLimitReset, ReleasePollReset,
              AutoOffReset};
      end
      CFG_WIDE: begin
        if ($urandom_range(0, 1) == 0) c.debounce_ticks = '1;
        if ($urandom_range(0, 1) == 0) c.hold_step_ticks = '1;
        if ($urandom_range(0, 1) == 0) c.hold_limit_ticks = '1;
        if ($urandom_range(0, 1) == 0) c.release_poll_ticks = '1;
        if ($urandom_range(0, 1) == 0) c.auto_off_ticks = '1;
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic send_tick(input logic lvl, input logic typed = 1'b0,
                           input result_t typed_res = '0);
    int unsigned gap;
    result_t predicted;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    button_level_i <= lvl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = advance_tick(lvl);
    led_events_due.push_back(typed ? typed_res : predicted);
    ticks_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (led_events_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_cfg(input cfg_t c);
    logic [RegIndexWidth-1:0] idx [5];
    logic [RegWidth-1:0] vals [5];
    idx = '{RegDebounce, RegHoldStep, RegHoldLimit, RegReleasePoll, RegAutoOff};
    vals = '{c.debounce_ticks, c.hold_step_ticks, c.hold_limit_ticks,
             c.release_poll_ticks, c.auto_off_ticks};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    // unmapped index: dropped by the block
    cfg_index_i <= RegIndexWidth'($urandom_range(RegAutoOff + 1, 2 ** RegIndexWidth - 1));
    cfg_wdata_i <= RegWidth'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg = c;
  endtask

  task automatic random_gesture();
    int unsigned span;
    int unsigned tail;
    span = cfg.debounce_ticks + cfg.hold_limit_ticks + 2 * cfg.hold_step_ticks + 2;
    if (span > 120) span = 120;
    tail = 2 * cfg.release_poll_ticks + 3;
    if (tail > 40) tail = 40;
    repeat ($urandom_range(0, 4)) send_tick(1'b1);
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 10)) send_tick(1'($urandom_range(0, 1)));
    end else begin
      repeat ($urandom_range(1, span)) send_tick($urandom_range(0, 19) == 0);
    end
    repeat ($urandom_range(1, tail)) send_tick($urandom_range(0, 19) != 0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (led_events_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction led_on %0b event_code %0d",
                 $time, led_on_o, event_code_o);
      end else begin
        head_due = led_events_due.pop_front();
        if (led_on_o !== head_due.led_on) begin
          errors++;
          $display("%0t: led_on expected %0b, got %0b", $time, head_due.led_on, led_on_o);
        end
        if (event_code_o !== head_due.event_code) begin
          errors++;
          $display("%0t: event_code expected %0d, got %0d",
                   $time, head_due.event_code, event_code_o);
        end
      end
      stall_left = quiet ? 0 : $urandom_range(0, 4);
    end else if (stall_left != 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left != 0);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IdleLimit) begin
      $display("button_long_press_led_controller_core: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned phase_end;
    cfg_mode_e mode;
    result_t typed_res;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].cfg_sel >= 0) begin
        settle();
        load_cfg(cfg_sets[directed[i].cfg_sel]);
      end
      typed_res.led_on = directed[i].led;
      typed_res.event_code = directed[i].ev;
      send_tick(directed[i].level, directed[i].typed, typed_res);
    end

    for (int ph = 0; ticks_sent < RandomTicks; ph++) begin
      mode = cfg_mode_e'(ph % 4);
      settle();
      load_cfg(pick_cfg(mode));
      quiet = (ph % 3 == 2);
      phase_end = ticks_sent + ((mode == CFG_SMALL || mode == CFG_ZEROS) ? 200 : 60);
      if (phase_end > RandomTicks) phase_end = RandomTicks;
      while (ticks_sent < phase_end) random_gesture();
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("button_long_press_led_controller_core: match");
    end else begin
      $display("button_long_press_led_controller_core: mismatch");
    end
    $finish;
  end

endmodule
